// File: rtl/core/scrs_pkg.sv
// shared types, codes and helpers for the smtp client reply sequencer
`default_nettype none
package scrs_pkg;

	localparam int LINE_CAPACITY_DEF  = 1024;
	localparam int MAX_RECIPIENTS_DEF = 64;
	localparam int PREFIX_LEN         = 12;
	localparam int PIDX_W             = $clog2(PREFIX_LEN);
	localparam int RCNT_W             = 7;
	localparam int IDX_W              = 6;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_OPENED,
		CMD_SECURED,
		CMD_CLOSED
	} cmd_t;

	typedef enum logic [3:0] {
		PH_GREETING,
		PH_EHLO,
		PH_STARTTLS,
		PH_EHLO_AGAIN,
		PH_AUTH,
		PH_AUTH_USER,
		PH_AUTH_PASSWORD,
		PH_FROM,
		PH_RCPT,
		PH_DATA,
		PH_BODY,
		PH_QUIT,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ACT_PROGRESS,
		ACT_EHLO,
		ACT_STARTTLS,
		ACT_UPGRADE,
		ACT_AUTH,
		ACT_USER,
		ACT_PASSWORD,
		ACT_MAIL,
		ACT_RCPT,
		ACT_DATA,
		ACT_BODY,
		ACT_DOT,
		ACT_QUIT,
		ACT_SENT,
		ACT_FAILED
	} action_t;

	// progress kinds
	localparam logic [3:0] PRG_CONNECTED   = 4'd0;
	localparam logic [3:0] PRG_HELLO       = 4'd1;
	localparam logic [3:0] PRG_ENCRYPTING  = 4'd2;
	localparam logic [3:0] PRG_SIGNING_IN  = 4'd3;
	localparam logic [3:0] PRG_SENDING     = 4'd4;
	localparam logic [3:0] PRG_HELLO_AGAIN = 4'd5;

	// failure reasons
	localparam logic [3:0] ERR_NO_GREETING    = 4'd0;
	localparam logic [3:0] ERR_EHLO           = 4'd1;
	localparam logic [3:0] ERR_NO_OFFER       = 4'd2;
	localparam logic [3:0] ERR_STARTTLS       = 4'd3;
	localparam logic [3:0] ERR_EHLO_AGAIN     = 4'd4;
	localparam logic [3:0] ERR_AUTH           = 4'd5;
	localparam logic [3:0] ERR_NO_PASS_PROMPT = 4'd6;
	localparam logic [3:0] ERR_CREDENTIALS    = 4'd7;
	localparam logic [3:0] ERR_SENDER         = 4'd8;
	localparam logic [3:0] ERR_RECIPIENT      = 4'd9;
	localparam logic [3:0] ERR_DATA           = 4'd10;
	localparam logic [3:0] ERR_MESSAGE        = 4'd11;
	localparam logic [3:0] ERR_CLOSED         = 4'd12;
	localparam logic [3:0] DET_NONE           = 4'd0;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LZ   = 8'h7a;

	// offer keyword, first character in the top byte
	localparam logic [63:0] OFFER_WORD = "STARTTLS";

	typedef struct packed {
		action_t          action;
		logic [3:0]       detail;
		logic [IDX_W-1:0] rcpt_idx;
	} result_t;

	// one finished reply line, as seen by the sequencer
	typedef struct packed {
		logic done;
		logic last;
		logic c220;
		logic c235;
		logic c250;
		logic c251;
		logic c334;
		logic c354;
		logic offer;
	} line_evt_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_LA && c <= CH_LZ) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic result_t make_res(input action_t a, input logic [3:0] d,
			input logic [IDX_W-1:0] i);
		result_t r;
		r.action   = a;
		r.detail   = d;
		r.rcpt_idx = i;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/smtp_client_reply_sequencer.sv
// top level of the smtp client reply sequencer
`default_nettype none
//
// channel   direction  handshake                       contents
// s_axis    in         s_axis_tvalid / s_axis_tready   tuser command, tdata data_byte
// m_axis    out        m_axis_tvalid / m_axis_tready   tuser action, tdata detail and
//                                                      recipient_index, tlast last
// apb       in         psel, penable, pwrite, pready   starttls_mode at 0x0,
//                                                      recipient_count at 0x4
//
// each request is captured in the input register and handled by the line assembler and the
// phase machine once the result register has room; they load zero, one or two results into
// the result register; one request per cycle while results are taken as they appear
// after a request that causes two results, the next request waits in the input register
// while the first result drains through the single output port of the result register
// reset clears phase, line state, offer flag and recipient counter at once; no clearing pass
// a stalled output holds the result register and then the input register, and
// s_axis_tready drops only while both are occupied
//
module smtp_client_reply_sequencer import scrs_pkg::*; #(
	parameter int LINE_CAPACITY  = LINE_CAPACITY_DEF,
	parameter int MAX_RECIPIENTS = MAX_RECIPIENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [3:0] detail, [9:4] recipient_index, rest zero
	output logic [3:0]       m_axis_tuser,  // [3:0] action
	output logic             m_axis_tlast,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// register select, word address bit
	localparam logic REG_STARTTLS_MODE = 1'b0;
	localparam logic REG_RCPT_COUNT    = 1'b1;

	logic              starttls_mode_q;
	logic [RCNT_W-1:0] recipient_count_q;
	logic              cfg_wr;

	// input register
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] byte_s1;

	logic       room, step, upgrade;
	logic [1:0] res_cnt;
	result_t    res0, res1;
	line_evt_t  evt;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			starttls_mode_q   <= 1'b0;
			recipient_count_q <= RCNT_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_STARTTLS_MODE: starttls_mode_q   <= pwdata[0];
				REG_RCPT_COUNT:    recipient_count_q <= pwdata[RCNT_W-1:0];
				default: begin
					starttls_mode_q <= starttls_mode_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_STARTTLS_MODE: prdata = {31'd0, starttls_mode_q};
			REG_RCPT_COUNT:    prdata = {{(32-RCNT_W){1'b0}}, recipient_count_q};
			default:           prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// the held request is handled when the result register can take its results
	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	// ---------------- line assembly ----------------
	// strips carriage returns, drops long lines and parses the reply header
	scrs_line_buf #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.upgrade   (upgrade),
		.evt       (evt)
	);

	// ---------------- session sequencing ----------------
	scrs_sequencer #(
		.MAX_RECIPIENTS(MAX_RECIPIENTS)
	) u_sequencer (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.cmd             (cmd_s1),
		.evt             (evt),
		.starttls_mode   (starttls_mode_q),
		.recipient_count (recipient_count_q),
		.upgrade         (upgrade),
		.res_cnt         (res_cnt),
		.res0            (res0),
		.res1            (res1)
	);

	// ---------------- result register ----------------
	scrs_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step),
		.res_cnt       (res_cnt),
		.res0          (res0),
		.res1          (res1),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: rtl/core/scrs_line_buf.sv
// line assembly, prefix capture and reply line parsing
`default_nettype none
module scrs_line_buf import scrs_pkg::*; #(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire cmd_t      cmd,
	input  wire logic [7:0] data_byte,
	input  wire logic      upgrade,
	output line_evt_t      evt
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             discard_q;
	logic [7:0]       prefix_q [PREFIX_LEN];

	logic is_byte, is_lf, is_cr, reply_ok, match, wr_prefix;
	logic [7:0] p0, p1, p2, p3;

	assign p0 = prefix_q[0];
	assign p1 = prefix_q[1];
	assign p2 = prefix_q[2];
	assign p3 = prefix_q[3];

	assign is_byte = (cmd == CMD_BYTE) && !discard_q;
	assign is_lf   = (data_byte == CH_LF);
	assign is_cr   = (data_byte == CH_CR);

	assign reply_ok = (len_q >= LEN_W'(4))
		&& p0 >= CH_ZERO && p0 <= CH_NINE
		&& p1 >= CH_ZERO && p1 <= CH_NINE
		&& p2 >= CH_ZERO && p2 <= CH_NINE
		&& (p3 == CH_SP || p3 == CH_DASH);

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (to_upper(prefix_q[4+i]) != OFFER_WORD[63-8*i -: 8]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		evt.done  = is_byte && is_lf && !ovf_q && reply_ok;
		evt.last  = (p3 == CH_SP);
		evt.c220  = (p0 == "2") && (p1 == "2") && (p2 == "0");
		evt.c235  = (p0 == "2") && (p1 == "3") && (p2 == "5");
		evt.c250  = (p0 == "2") && (p1 == "5") && (p2 == "0");
		evt.c251  = (p0 == "2") && (p1 == "5") && (p2 == "1");
		evt.c334  = (p0 == "3") && (p1 == "3") && (p2 == "4");
		evt.c354  = (p0 == "3") && (p1 == "5") && (p2 == "4");
		evt.offer = (len_q >= LEN_W'(PREFIX_LEN)) && evt.c250 && match;
	end

	assign wr_prefix = step && is_byte && !is_cr && !is_lf
		&& (len_q < LEN_W'(LINE_CAPACITY - 1)) && (len_q < LEN_W'(PREFIX_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			ovf_q     <= 1'b0;
			discard_q <= 1'b0;
		end else if (step) begin
			if (cmd == CMD_SECURED) begin
				discard_q <= 1'b0;
			end else if (upgrade) begin
				discard_q <= 1'b1;
			end
			if (is_byte && !is_cr) begin
				if (is_lf) begin
					len_q <= '0;
					ovf_q <= 1'b0;
				end else if (len_q >= LEN_W'(LINE_CAPACITY - 1)) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PREFIX_LEN; i++) begin
			if (wr_prefix && len_q[PIDX_W-1:0] == PIDX_W'(i)) begin
				prefix_q[i] <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/scrs_sequencer.sv
// session phase machine, offer flag and recipient counter
`default_nettype none
module scrs_sequencer import scrs_pkg::*; #(
	parameter int MAX_RECIPIENTS = MAX_RECIPIENTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire cmd_t              cmd,
	input  wire line_evt_t         evt,
	input  wire logic              starttls_mode,
	input  wire logic [RCNT_W-1:0] recipient_count,
	output logic                   upgrade,
	output logic [1:0]             res_cnt,
	output result_t                res0,
	output result_t                res1
);

	localparam logic [8:0] MAX_CNT = 9'(MAX_RECIPIENTS);

	phase_t            phase_q, phase_d;
	logic              offer_q, offer_d, offer_now;
	logic [RCNT_W-1:0] pos_q, pos_d;
	logic [RCNT_W:0]   pos_inc;
	logic [8:0]        cnt_ext, eff_cnt;
	result_t           nil;

	assign nil     = make_res(ACT_PROGRESS, DET_NONE, '0);
	assign pos_inc = {1'b0, pos_q} + (RCNT_W+1)'(1);
	assign cnt_ext = {2'b00, recipient_count};

	always_comb begin
		if (recipient_count == '0) begin
			eff_cnt = 9'd1;
		end else if (cnt_ext > MAX_CNT) begin
			eff_cnt = MAX_CNT;
		end else begin
			eff_cnt = cnt_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GREETING;
			offer_q <= 1'b0;
			pos_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			offer_q <= offer_d;
			pos_q   <= pos_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		offer_d   = offer_q;
		pos_d     = pos_q;
		upgrade   = 1'b0;
		res_cnt   = 2'd0;
		res0      = nil;
		res1      = nil;
		offer_now = offer_q | (evt.offer && (phase_q == PH_EHLO || phase_q == PH_EHLO_AGAIN));
		case (cmd)
			CMD_OPENED: begin
				res_cnt = 2'd1;
				res0    = make_res(ACT_PROGRESS, PRG_CONNECTED, '0);
			end
			CMD_SECURED: begin
				offer_d = 1'b0;
				phase_d = PH_EHLO_AGAIN;
				res_cnt = 2'd2;
				res0    = make_res(ACT_PROGRESS, PRG_HELLO_AGAIN, '0);
				res1    = make_res(ACT_EHLO, DET_NONE, '0);
			end
			CMD_CLOSED: begin
				phase_d = PH_DONE;
				if (phase_q != PH_QUIT && phase_q != PH_DONE) begin
					res_cnt = 2'd1;
					res0    = make_res(ACT_FAILED, ERR_CLOSED, '0);
				end
			end
			CMD_BYTE: begin
				if (evt.done) begin
					offer_d = offer_now;
					if (evt.last) begin
						res_cnt = 2'd1;
						case (phase_q)
							PH_GREETING: begin
								if (!evt.c220) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_NO_GREETING, '0);
								end else begin
									phase_d = PH_EHLO;
									res_cnt = 2'd2;
									res0    = make_res(ACT_PROGRESS, PRG_HELLO, '0);
									res1    = make_res(ACT_EHLO, DET_NONE, '0);
								end
							end
							PH_EHLO: begin
								if (!evt.c250) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_EHLO, '0);
								end else if (starttls_mode && !offer_now) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_NO_OFFER, '0);
								end else if (starttls_mode) begin
									phase_d = PH_STARTTLS;
									res_cnt = 2'd2;
									res0    = make_res(ACT_PROGRESS, PRG_ENCRYPTING, '0);
									res1    = make_res(ACT_STARTTLS, DET_NONE, '0);
								end else begin
									phase_d = PH_AUTH;
									res_cnt = 2'd2;
									res0    = make_res(ACT_PROGRESS, PRG_SIGNING_IN, '0);
									res1    = make_res(ACT_AUTH, DET_NONE, '0);
								end
							end
							PH_STARTTLS: begin
								if (!evt.c220) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_STARTTLS, '0);
								end else begin
									upgrade = 1'b1;
									res0    = make_res(ACT_UPGRADE, DET_NONE, '0);
								end
							end
							PH_EHLO_AGAIN: begin
								if (!evt.c250) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_EHLO_AGAIN, '0);
								end else begin
									phase_d = PH_AUTH;
									res_cnt = 2'd2;
									res0    = make_res(ACT_PROGRESS, PRG_SIGNING_IN, '0);
									res1    = make_res(ACT_AUTH, DET_NONE, '0);
								end
							end
							PH_AUTH: begin
								if (!evt.c334) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_AUTH, '0);
								end else begin
									phase_d = PH_AUTH_USER;
									res0    = make_res(ACT_USER, DET_NONE, '0);
								end
							end
							PH_AUTH_USER: begin
								if (!evt.c334) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_NO_PASS_PROMPT, '0);
								end else begin
									phase_d = PH_AUTH_PASSWORD;
									res0    = make_res(ACT_PASSWORD, DET_NONE, '0);
								end
							end
							PH_AUTH_PASSWORD: begin
								if (!evt.c235) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_CREDENTIALS, '0);
								end else begin
									phase_d = PH_FROM;
									res_cnt = 2'd2;
									res0    = make_res(ACT_PROGRESS, PRG_SENDING, '0);
									res1    = make_res(ACT_MAIL, DET_NONE, '0);
								end
							end
							PH_FROM: begin
								if (!evt.c250) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_SENDER, '0);
								end else begin
									phase_d = PH_RCPT;
									pos_d   = '0;
									res0    = make_res(ACT_RCPT, DET_NONE, '0);
								end
							end
							PH_RCPT: begin
								if (!evt.c250 && !evt.c251) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_RECIPIENT,
										pos_q[IDX_W-1:0]);
								end else begin
									pos_d = pos_inc[RCNT_W-1:0];
									if (9'(pos_inc) < eff_cnt) begin
										res0 = make_res(ACT_RCPT, DET_NONE, pos_inc[IDX_W-1:0]);
									end else begin
										phase_d = PH_DATA;
										res0    = make_res(ACT_DATA, DET_NONE, '0);
									end
								end
							end
							PH_DATA: begin
								if (!evt.c354) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_DATA, '0);
								end else begin
									phase_d = PH_BODY;
									res_cnt = 2'd2;
									res0    = make_res(ACT_BODY, DET_NONE, '0);
									res1    = make_res(ACT_DOT, DET_NONE, '0);
								end
							end
							PH_BODY: begin
								if (!evt.c250) begin
									phase_d = PH_DONE;
									res0    = make_res(ACT_FAILED, ERR_MESSAGE, '0);
								end else begin
									phase_d = PH_QUIT;
									res_cnt = 2'd2;
									res0    = make_res(ACT_QUIT, DET_NONE, '0);
									res1    = make_res(ACT_SENT, DET_NONE, '0);
								end
							end
							default: begin
								// quit sent or session over: replies cause nothing
								phase_d = PH_DONE;
								res_cnt = 2'd0;
							end
						endcase
					end
				end
			end
			default: begin
				res_cnt = 2'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/scrs_out_buf.sv
// two-slot result register feeding the output stream
`default_nettype none
module scrs_out_buf import scrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [1:0] res_cnt,
	input  wire result_t    res0,
	input  wire result_t    res1,
	output logic            room,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [15:0]     m_axis_tdata,  // [3:0] detail, [9:4] recipient_index, rest zero
	output logic [3:0]      m_axis_tuser,  // [3:0] action
	output logic            m_axis_tlast
);

	logic [1:0] cnt_q;
	result_t    head_q, tail_q;
	logic       pop;

	assign pop  = (cnt_q != 2'd0) && m_axis_tready;
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tlast  = (cnt_q == 2'd1);
	assign m_axis_tuser  = head_q.action;
	assign m_axis_tdata  = {6'd0, head_q.rcpt_idx, head_q.detail};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res0;
			tail_q <= res1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule
`default_nettype wire

// File: tb/smtp_client_reply_sequencer_tb.sv
// testbench for the smtp client reply sequencer: scripted and random server sessions checked
`timescale 1ns / 100ps

module smtp_client_reply_sequencer_tb;
	import scrs_pkg::*;

	// reply codes the client reacts to
	localparam int RC_READY       = 220;
	localparam int RC_BYE         = 221;
	localparam int RC_AUTH_OK     = 235;
	localparam int RC_OK          = 250;
	localparam int RC_FORWARD     = 251;
	localparam int RC_CHALLENGE   = 334;
	localparam int RC_START_INPUT = 354;

	// register map
	localparam logic [2:0] REG_TLS_MODE   = 3'h0;
	localparam logic [2:0] REG_RCPT_COUNT = 3'h4;

	localparam logic [63:0] OFFER_KEY = "STARTTLS";

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 150;
	localparam int REPORT_LIMIT  = 10;

	// one request toward the block
	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
	} server_event_t;

	// one result the block owes
	typedef struct {
		action_t          act;
		logic [3:0]       det;
		logic [IDX_W-1:0] idx;
		logic             fin;
	} reply_action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [3:0] detail, [9:4] recipient_index, rest zero
	logic [3:0]  m_axis_tuser;           // [3:0] action
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// requests waiting for the driver and results waiting for the monitor
	server_event_t request_queue[$];
	reply_action_t actions_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// client session as the predictor sees it, reset values as after arst_n
	bit               tls_required = 1'b0;
	logic [6:0]       rcpt_cfg = 7'd1;
	phase_t           sess_phase = PH_GREETING;
	bit               offer_seen = 1'b0;
	int               line_len = 0;
	bit               line_dropped = 1'b0;
	bit               upgrade_wait = 1'b0;
	logic [7:0]       line_head [PREFIX_LEN] = '{default: 8'h00};
	int               rcpt_pos = 0;

	smtp_client_reply_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endfunction

	// recipient count as the sequencer applies it: zero acts as one, large values saturate
	function automatic int recipients_in_use();
		int c;
		c = rcpt_cfg;
		if (c == 0) begin
			c = 1;
		end
		if (c > MAX_RECIPIENTS_DEF) begin
			c = MAX_RECIPIENTS_DEF;
		end
		return c;
	endfunction

	function automatic void emit(input action_t a, input logic [3:0] d, input int idx);
		reply_action_t r;
		r.act = a;
		r.det = d;
		r.idx = idx[IDX_W-1:0];
		r.fin = 1'b0;
		actions_due.push_back(r);
	endfunction

	function automatic void fail_with(input logic [3:0] reason, input int idx);
		sess_phase = PH_DONE;
		emit(ACT_FAILED, reason, idx);
	endfunction

	// predictor: one accepted request in, expected results appended to actions_due
	task automatic step_session(input cmd_t cmd, input logic [7:0] b);
		int         queued;
		int         n;
		int         code;
		int         i;
		bit         is_reply;
		bit         final_line;
		bit         offered;
		logic [7:0] ch;
		queued = actions_due.size();
		case (cmd)
			CMD_BYTE: begin
				// bytes are dropped during an upgrade, carriage returns always
				if (!upgrade_wait && b != CH_CR) begin
					if (b == CH_LF) begin
						if (line_dropped) begin
							line_dropped = 1'b0;
						end else begin
							// a zero byte cuts the line short for parsing
							n = line_len;
							for (i = 0; i < PREFIX_LEN; i++) begin
								if (i < n && line_head[i] == 8'h00) begin
									n = i;
								end
							end
							is_reply = n >= 4 &&
								(line_head[3] == CH_SP || line_head[3] == CH_DASH);
							for (i = 0; i < 3; i++) begin
								if (line_head[i] < CH_ZERO || line_head[i] > CH_NINE) begin
									is_reply = 1'b0;
								end
							end
							if (is_reply) begin
								code = (line_head[0] - CH_ZERO) * 100 +
									(line_head[1] - CH_ZERO) * 10 + (line_head[2] - CH_ZERO);
								final_line = line_head[3] == CH_SP;
								// starttls offer, any case, right after the code
								if ((sess_phase == PH_EHLO || sess_phase == PH_EHLO_AGAIN) &&
										code == RC_OK && n >= PREFIX_LEN) begin
									offered = 1'b1;
									for (i = 0; i < 8; i++) begin
										ch = line_head[4 + i];
										if (ch >= CH_LA && ch <= CH_LZ) begin
											ch = ch - 8'd32;
										end
										if (ch != OFFER_KEY[63 - 8 * i -: 8]) begin
											offered = 1'b0;
										end
									end
									if (offered) begin
										offer_seen = 1'b1;
									end
								end
								if (final_line) begin
									case (sess_phase)
										PH_GREETING: begin
											if (code != RC_READY) begin
												fail_with(ERR_NO_GREETING, 0);
											end else begin
												sess_phase = PH_EHLO;
												emit(ACT_PROGRESS, PRG_HELLO, 0);
												emit(ACT_EHLO, DET_NONE, 0);
											end
										end
										PH_EHLO: begin
											if (code != RC_OK) begin
												fail_with(ERR_EHLO, 0);
											end else if (tls_required && !offer_seen) begin
												fail_with(ERR_NO_OFFER, 0);
											end else if (tls_required) begin
												sess_phase = PH_STARTTLS;
												emit(ACT_PROGRESS, PRG_ENCRYPTING, 0);
												emit(ACT_STARTTLS, DET_NONE, 0);
											end else begin
												sess_phase = PH_AUTH;
												emit(ACT_PROGRESS, PRG_SIGNING_IN, 0);
												emit(ACT_AUTH, DET_NONE, 0);
											end
										end
										PH_STARTTLS: begin
											if (code != RC_READY) begin
												fail_with(ERR_STARTTLS, 0);
											end else begin
												line_dropped = 1'b0;
												upgrade_wait = 1'b1;
												emit(ACT_UPGRADE, DET_NONE, 0);
											end
										end
										PH_EHLO_AGAIN: begin
											if (code != RC_OK) begin
												fail_with(ERR_EHLO_AGAIN, 0);
											end else begin
												sess_phase = PH_AUTH;
												emit(ACT_PROGRESS, PRG_SIGNING_IN, 0);
												emit(ACT_AUTH, DET_NONE, 0);
											end
										end
										PH_AUTH: begin
											if (code != RC_CHALLENGE) begin
												fail_with(ERR_AUTH, 0);
											end else begin
												sess_phase = PH_AUTH_USER;
												emit(ACT_USER, DET_NONE, 0);
											end
										end
										PH_AUTH_USER: begin
											if (code != RC_CHALLENGE) begin
												fail_with(ERR_NO_PASS_PROMPT, 0);
											end else begin
												sess_phase = PH_AUTH_PASSWORD;
												emit(ACT_PASSWORD, DET_NONE, 0);
											end
										end
										PH_AUTH_PASSWORD: begin
											if (code != RC_AUTH_OK) begin
												fail_with(ERR_CREDENTIALS, 0);
											end else begin
												sess_phase = PH_FROM;
												emit(ACT_PROGRESS, PRG_SENDING, 0);
												emit(ACT_MAIL, DET_NONE, 0);
											end
										end
										PH_FROM: begin
											if (code != RC_OK) begin
												fail_with(ERR_SENDER, 0);
											end else begin
												sess_phase = PH_RCPT;
												rcpt_pos = 0;
												emit(ACT_RCPT, DET_NONE, 0);
											end
										end
										PH_RCPT: begin
											if (code != RC_OK && code != RC_FORWARD) begin
												fail_with(ERR_RECIPIENT, rcpt_pos);
											end else begin
												rcpt_pos++;
												if (rcpt_pos < recipients_in_use()) begin
													emit(ACT_RCPT, DET_NONE, rcpt_pos);
												end else begin
													sess_phase = PH_DATA;
													emit(ACT_DATA, DET_NONE, 0);
												end
											end
										end
										PH_DATA: begin
											if (code != RC_START_INPUT) begin
												fail_with(ERR_DATA, 0);
											end else begin
												sess_phase = PH_BODY;
												emit(ACT_BODY, DET_NONE, 0);
												emit(ACT_DOT, DET_NONE, 0);
											end
										end
										PH_BODY: begin
											if (code != RC_OK) begin
												fail_with(ERR_MESSAGE, 0);
											end else begin
												sess_phase = PH_QUIT;
												emit(ACT_QUIT, DET_NONE, 0);
												emit(ACT_SENT, DET_NONE, 0);
											end
										end
										default: begin
											sess_phase = PH_DONE;
										end
									endcase
								end
							end
						end
						line_len = 0;
					end else if (line_len + 1 >= LINE_CAPACITY_DEF) begin
						// too long: the whole line goes when its line feed comes
						line_dropped = 1'b1;
					end else begin
						if (line_len < PREFIX_LEN) begin
							line_head[line_len] = b;
						end
						line_len++;
					end
				end
			end
			CMD_OPENED: begin
				emit(ACT_PROGRESS, PRG_CONNECTED, 0);
			end
			CMD_SECURED: begin
				// restarts at the encrypted hello from any phase
				upgrade_wait = 1'b0;
				offer_seen = 1'b0;
				sess_phase = PH_EHLO_AGAIN;
				emit(ACT_PROGRESS, PRG_HELLO_AGAIN, 0);
				emit(ACT_EHLO, DET_NONE, 0);
			end
			default: begin
				// a close after quit is the normal end
				if (sess_phase == PH_QUIT || sess_phase == PH_DONE) begin
					sess_phase = PH_DONE;
				end else begin
					fail_with(ERR_CLOSED, 0);
				end
			end
		endcase
		if (actions_due.size() > queued) begin
			actions_due[actions_due.size() - 1].fin = 1'b1;
		end
	endtask

	// request driver: holds a request until taken, may idle between requests
	always @(posedge clk or negedge arst_n) begin
		server_event_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tuser  <= CMD_BYTE;
			s_axis_tdata  <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				step_session(cmd_t'(s_axis_tuser), s_axis_tdata);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = request_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= nxt.cmd;
					s_axis_tdata  <= nxt.data;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
	end

	// result monitor: every taken result against the oldest one due
	always @(posedge clk) begin
		reply_action_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (actions_due.size() == 0) begin
				note_mismatch($sformatf("unexpected result action %0d tdata %0h last %0b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast));
			end else begin
				due = actions_due.pop_front();
				if (m_axis_tuser !== due.act || m_axis_tdata[3:0] !== due.det ||
						m_axis_tdata[9:4] !== due.idx || m_axis_tdata[15:10] !== 6'd0 ||
						m_axis_tlast !== due.fin) begin
					note_mismatch($sformatf({"expected action %0d detail %0d index %0d last %0b,",
						" got action %0d detail %0d index %0d pad %0h last %0b"},
						due.act, due.det, due.idx, due.fin, m_axis_tuser, m_axis_tdata[3:0],
						m_axis_tdata[9:4], m_axis_tdata[15:10], m_axis_tlast));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_read(input logic [2:0] addr);
		logic [31:0] want;
		want = (addr == REG_TLS_MODE) ? {31'd0, tls_required} : {25'd0, rcpt_cfg};
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			note_mismatch($sformatf("register %0h: expected %0h, got %0h", addr, want, prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// write, then read back; only called while the block is idle
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_TLS_MODE) begin
			tls_required = value[0];
		end else if (addr == REG_RCPT_COUNT) begin
			rcpt_cfg = value[6:0];
		end
		apb_read(addr);
	endtask

	// all requests taken, all results seen, then a settling wait for silent work
	task automatic wait_quiet();
		while (request_queue.size() != 0 || s_axis_tvalid || actions_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_req(input cmd_t c, input logic [7:0] b);
		server_event_t e;
		e.cmd  = c;
		e.data = b;
		request_queue.push_back(e);
	endfunction

	function automatic void push_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			push_req(CMD_BYTE, s[i]);
		end
	endfunction

	// stray carriage returns land anywhere in a line
	function automatic void push_byte(input logic [7:0] b);
		if ($urandom_range(99) < 6) begin
			push_req(CMD_BYTE, CH_CR);
		end
		push_req(CMD_BYTE, b);
	endfunction

	// one reply line with random text, sometimes the starttls keyword in random case
	function automatic void push_reply(input int code, input bit final_line);
		int         i;
		logic [7:0] ch;
		push_byte(8'(CH_ZERO + code / 100));
		push_byte(8'(CH_ZERO + (code / 10) % 10));
		push_byte(8'(CH_ZERO + code % 10));
		push_byte(final_line ? CH_SP : CH_DASH);
		if ($urandom_range(4) == 0) begin
			for (i = 0; i < 8; i++) begin
				ch = OFFER_KEY[63 - 8 * i -: 8];
				push_byte($urandom_range(1) ? ch + 8'd32 : ch);
			end
		end else begin
			repeat ($urandom_range(10)) begin
				push_byte($urandom_range(99) == 0 ? 8'h00 : 8'($urandom_range(126, 32)));
			end
		end
		push_byte(CH_LF);
	endfunction

	// a full reply: maybe noise or an opened event first, maybe continuation lines
	function automatic void answer(input int code);
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(16)) push_req(CMD_BYTE, 8'($urandom_range(255)));
			push_byte(CH_LF);
		end
		if ($urandom_range(99) < 4) begin
			push_req(CMD_OPENED, 8'($urandom_range(255)));
		end
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(2, 1)) push_reply(code, 1'b0);
		end
		push_reply(code, 1'b1);
	endfunction

	// one setting of registers and handshake pressure, filled with encrypted sessions
	task automatic run_phase(input bit mode, input logic [6:0] count, input int idle_pct,
			input int stall_pct);
		int steps[$];
		int fail_at;
		int k;
		bit ended;
		wait_quiet();
		apb_write(REG_TLS_MODE, {31'd0, mode});
		apb_write(REG_RCPT_COUNT, {25'd0, count});
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		while (request_queue.size() < PHASE_ITEMS) begin
			if ($urandom_range(4) == 0) begin
				push_req(CMD_OPENED, 8'($urandom_range(255)));
			end
			// greeting and first hello happen once per reset, so sessions enter encrypted
			push_req(CMD_SECURED, 8'($urandom_range(255)));
			steps = '{RC_OK, RC_CHALLENGE, RC_CHALLENGE, RC_AUTH_OK, RC_OK};
			repeat (recipients_in_use()) steps.push_back($urandom_range(1) ? RC_OK : RC_FORWARD);
			steps.push_back(RC_START_INPUT);
			steps.push_back(RC_OK);
			// about a third of the sessions break at one random step
			fail_at = ($urandom_range(9) < 3) ? $urandom_range(steps.size() - 1) : -1;
			ended = 1'b0;
			for (k = 0; k < steps.size() && !ended; k++) begin
				if (k == fail_at) begin
					ended = 1'b1;
					if ($urandom_range(1)) begin
						answer($urandom_range(599, 100));
					end else begin
						push_req(CMD_CLOSED, 8'($urandom_range(255)));
					end
				end else begin
					answer(steps[k]);
				end
			end
			if (!ended) begin
				if ($urandom_range(2) != 0) begin
					answer(RC_BYE);
				end
				push_req(CMD_CLOSED, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// reset values, then the starttls setting for the scripted session
		apb_read(REG_TLS_MODE);
		apb_read(REG_RCPT_COUNT);
		apb_write(REG_TLS_MODE, 32'd1);
		apb_write(REG_RCPT_COUNT, 32'd2);

		// scripted session through greeting, starttls upgrade and the whole send
		push_req(CMD_OPENED, 8'hff);
		push_text("220 mx ready\r\n");
		push_text("hello\n");
		push_text("250\n");
		push_text("25");
		push_req(CMD_BYTE, 8'h00);
		push_text("0 x\n");
		push_text("250-mx\r\n250-StartTLS\r\n250 SIZE\r\n");
		push_text("220 go\r\n");
		// swallowed while the upgrade is pending
		push_text("250 x\n");
		push_req(CMD_BYTE, 8'hff);
		push_req(CMD_SECURED, 8'h00);
		push_text("250 ok\n334 \n334 \n235 \n250 \n251 \n250 \n354 \n250 \n221 \n");
		push_req(CMD_CLOSED, 8'h00);
		// done: lines cause nothing, another close stays quiet
		push_text("220 \n");
		push_req(CMD_CLOSED, 8'h55);
		wait_quiet();

		// one byte over the longest kept line, then the longest kept line
		push_req(CMD_SECURED, 8'haa);
		push_text("250 ");
		repeat (LINE_CAPACITY_DEF - 4) push_req(CMD_BYTE, "x");
		push_text("\n250 ");
		repeat (LINE_CAPACITY_DEF - 5) push_req(CMD_BYTE, "y");
		push_text("\r\n");
		push_req(CMD_CLOSED, 8'h0f);
		wait_quiet();

		// random sessions under several settings and pressures
		run_phase(1'b0, 7'd0, 0, 0);
		run_phase(1'b1, 7'd64, 50, 0);
		run_phase(1'b0, 7'd127, 0, 50);
		run_phase(1'b1, 7'd1, 8, 8);
		run_phase(1'b0, 7'd65, 0, 0);
		run_phase(1'b1, 7'($urandom_range(5, 2)), 50, 0);
		run_phase(1'b0, 7'd3, 0, 50);
		run_phase(1'b1, 7'($urandom_range(8, 1)), 8, 8);
		wait_quiet();

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
